### sv/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk_i, disabled while rst_ni is low.
`define SBF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication from one condition to a condition in the next cycle.
`define SBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  `SBF_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

### sv/sbf_pkg.sv
// Package with types and codes shared by the sender blocklist filter.
package sbf_pkg;

  localparam logic [1:0] REQ_FRAME  = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  localparam logic [3:0] ST_DELIVER     = 4'd0;
  localparam logic [3:0] ST_BLOCKED     = 4'd1;
  localparam logic [3:0] ST_FRAME_ERROR = 4'd2;
  localparam logic [3:0] ST_NO_FRAME    = 4'd3;
  localparam logic [3:0] ST_ADDED       = 4'd4;
  localparam logic [3:0] ST_FULL        = 4'd5;
  localparam logic [3:0] ST_ALREADY     = 4'd6;
  localparam logic [3:0] ST_REMOVED     = 4'd7;
  localparam logic [3:0] ST_NOT_LISTED  = 4'd8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE
  } state_e;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage

### sv/sbf_ram.sv
// Generic single write port RAM with a registered read port.
module sbf_ram #(
  parameter int Width = 16,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/sbf_datapath.sv
// Datapath of the sender blocklist filter: table, scan compare and result register.
module sbf_datapath #(
  parameter int LIST_ENTRIES = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_wdata_i,
  input  logic [1:0]     req_type_i,
  input  logic [15:0]    item_address_i,
  input  logic [7:0]     frame_protocol_i,
  input  logic           frame_present_i,
  input  sbf_pkg::cmd_t  cmd_i,
  output sbf_pkg::stat_t stat_o,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output logic [3:0]     status_o
);

  import sbf_pkg::*;

  localparam int IdxW = (LIST_ENTRIES > 1) ? $clog2(LIST_ENTRIES) : 1;

  logic [7:0]              proto_code_q;
  logic [1:0]              req_q;
  logic [15:0]             addr_q;
  logic [7:0]              proto_q;
  logic                    present_q;
  logic [IdxW-1:0]         rd_idx_q;
  logic                    cmp_en_q;
  logic [IdxW-1:0]         cmp_idx_q;
  logic                    cmp_vld_q;
  logic                    match_found_q;
  logic [IdxW-1:0]         match_slot_q;
  logic                    free_found_q;
  logic [IdxW-1:0]         free_slot_q;
  logic [LIST_ENTRIES-1:0] valid_q;
  logic                    out_valid_q;
  logic [3:0]              status_q;
  logic [3:0]              status_d;
  logic [15:0]             ram_rdata;
  logic [15:0]             entry;
  logic                    ram_we;
  logic                    rm_en;

  sbf_ram #(
    .Width(16),
    .Depth(LIST_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(free_slot_q),
    .wdata_i(addr_q),
    .raddr_i(rd_idx_q),
    .rdata_o(ram_rdata)
  );

  assign entry = cmp_vld_q ? ram_rdata : 16'd0;

  always_comb begin
    case (req_q)
      REQ_FRAME: begin
        if (!present_q) begin
          status_d = ST_NO_FRAME;
        end else if (match_found_q) begin
          status_d = ST_BLOCKED;
        end else if (proto_q == proto_code_q) begin
          status_d = ST_DELIVER;
        end else begin
          status_d = ST_FRAME_ERROR;
        end
      end
      REQ_ADD: begin
        if (match_found_q) begin
          status_d = ST_ALREADY;
        end else if (free_found_q) begin
          status_d = ST_ADDED;
        end else begin
          status_d = ST_FULL;
        end
      end
      REQ_REMOVE: begin
        status_d = match_found_q ? ST_REMOVED : ST_NOT_LISTED;
      end
      default: begin
        status_d = ST_NO_FRAME;
      end
    endcase
  end

  assign ram_we = cmd_i.commit && (req_q == REQ_ADD) && !match_found_q && free_found_q;
  assign rm_en  = cmd_i.commit && (req_q == REQ_REMOVE) && match_found_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q     <= req_type_i;
      addr_q    <= item_address_i;
      proto_q   <= frame_protocol_i;
      present_q <= frame_present_i;
    end
    cmp_idx_q <= rd_idx_q;
    cmp_vld_q <= valid_q[rd_idx_q];
    if (cmd_i.commit) begin
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proto_code_q  <= 8'd0;
      rd_idx_q      <= '0;
      cmp_en_q      <= 1'b0;
      match_found_q <= 1'b0;
      match_slot_q  <= '0;
      free_found_q  <= 1'b0;
      free_slot_q   <= '0;
      valid_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        proto_code_q <= cfg_wdata_i;
      end
      cmp_en_q <= cmd_i.scan;
      if (cmd_i.start) begin
        rd_idx_q      <= '0;
        match_found_q <= 1'b0;
        free_found_q  <= 1'b0;
      end else begin
        if (cmd_i.scan && !stat_o.scan_last) begin
          rd_idx_q <= rd_idx_q + 1'b1;
        end
        if (cmp_en_q && !match_found_q && (entry == addr_q)) begin
          match_found_q <= 1'b1;
          match_slot_q  <= cmp_idx_q;
        end
        if (cmp_en_q && !free_found_q && (entry == 16'd0)) begin
          free_found_q <= 1'b1;
          free_slot_q  <= cmp_idx_q;
        end
      end
      if (ram_we) begin
        valid_q[free_slot_q] <= 1'b1;
      end
      if (rm_en) begin
        valid_q[match_slot_q] <= 1'b0;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.scan_last = (rd_idx_q == IdxW'(LIST_ENTRIES - 1));
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;

endmodule

### sv/sbf_ctrl.sv
// Controller state machine of the sender blocklist filter.
module sbf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sbf_pkg::stat_t stat_i,
  output sbf_pkg::cmd_t  cmd_o
);

  import sbf_pkg::*;

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### sv/sender_blocklist_filter.sv
// Each transaction is accepted in the idle state, then scanned against the table RAM one
// entry per cycle, then passed through the drain and decide steps of the controller; no
// new transaction is taken until the last one has been committed.
// A waiting result sits in an output register while the next transaction is taken.
// Reset clears the table at once through per-entry valid bits and sets the protocol code to 0.
module sender_blocklist_filter #(
  parameter int LIST_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] item_address_i,
  input  logic [7:0]  frame_protocol_i,
  input  logic        frame_present_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  status_o
);

  import sbf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sbf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  sbf_datapath #(
    .LIST_ENTRIES(LIST_ENTRIES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .req_type_i      (req_type_i),
    .item_address_i  (item_address_i),
    .frame_protocol_i(frame_protocol_i),
    .frame_present_i (frame_present_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o)
  );

endmodule

### sv/sbf_checker.sv
// Port-level checker for the sender blocklist filter and its bind statement.
`include "assert_macros.svh"

module sbf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  status_o
);

  import sbf_pkg::*;

  logic in_acc;
  logic out_hold;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_hold = out_valid_o && out_stall_i;

  `SBF_ASSERT_NEXT(a_out_hold, out_hold, out_valid_o && $stable(status_o), "result changed")
  `SBF_ASSERT(a_status_range, out_valid_o |-> (status_o <= ST_NOT_LISTED), "bad status code")
  `SBF_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall_o, "transaction taken while busy")
  `SBF_ASSERT_NEXT(a_no_instant_result, in_acc, !$rose(out_valid_o), "result appeared too early")

endmodule

bind sender_blocklist_filter sbf_checker u_sbf_checker (.*);
